@@ sv/rrht_pkg.sv @@
// Shared types, codes and method tables for the RTSP request header tokenizer.
// No dependencies; other files refer to it by scoped names or import it.
package rrht_pkg;

  localparam int NumMethods     = 11;
  localparam int MethodNameLen  = 13;
  localparam int MethodNameBits = MethodNameLen * 8;
  localparam int CfgIndexBits   = 2;
  localparam int CfgDataBits    = 13;
  localparam int NumLimits      = 4;

  localparam logic [NumMethods-1:0] AllCandidates = '1;
  localparam logic [3:0]            MethodLenMax  = 4'd15;

  localparam logic [7:0] PrintLow  = 8'd33;
  localparam logic [7:0] PrintHigh = 8'd126;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;

  // Register indexes on the configuration port
  typedef enum logic [CfgIndexBits-1:0] {
    CfgMaxUrl     = 2'd0,
    CfgMaxVersion = 2'd1,
    CfgMaxName    = 2'd2,
    CfgMaxValue   = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    RoleMethod  = 3'd0,
    RoleUrl     = 3'd1,
    RoleVersion = 3'd2,
    RoleName    = 3'd3,
    RoleValue   = 3'd4,
    RoleDelim   = 3'd5,
    RoleMark    = 3'd6,
    RoleNone    = 3'd7
  } role_e;

  typedef enum logic [2:0] {
    CauseNone   = 3'd0,
    CauseChar   = 3'd1,
    CauseMethod = 3'd2,
    CauseLength = 3'd3,
    CauseEol    = 3'd4
  } cause_e;

  typedef struct packed {
    cause_e     error_cause;
    logic       error;
    logic       request_done;
    logic [3:0] method_code;
    logic       field_end;
    role_e      role;
    logic [7:0] byte_out;
  } result_t;

  // Names are right-justified in the vector: first char sits highest.
  localparam logic [MethodNameBits-1:0] MethodNames [NumMethods] = '{
    "DESCRIBE", "ANNOUNCE", "GET_PARAMETER", "OPTIONS", "PAUSE", "PLAY",
    "RECORD", "REDIRECT", "SETUP", "SET_PARAMETER", "TEARDOWN"
  };
  localparam logic [3:0] MethodLens [NumMethods] = '{
    4'd8, 4'd8, 4'd13, 4'd7, 4'd5, 4'd4, 4'd6, 4'd8, 4'd5, 4'd13, 4'd8
  };

  // Character at position pos of method k (meaningless when pos >= length)
  function automatic logic [7:0] method_char(input logic [3:0] k, input logic [3:0] pos);
    logic [3:0] idx;
    idx = 4'(MethodLens[k] - 4'd1 - pos);
    return MethodNames[k][{idx, 3'b000} +: 8];
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= PrintLow) && (b <= PrintHigh);
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return (b >= ChUpperA) && (b <= ChUpperZ);
  endfunction

endpackage

@@ sv/rrht_method_match.sv @@
// Method name matcher: narrows the candidate vector by one byte and reports
// the method that fits the current candidates and length. Uses rrht_pkg.
module rrht_method_match (
  input  logic [rrht_pkg::NumMethods-1:0] cand_i,
  input  logic [3:0]                      len_i,
  input  logic [7:0]                      byte_i,
  output logic [rrht_pkg::NumMethods-1:0] cand_o,
  output logic [3:0]                      len_o,
  output logic [3:0]                      code_o
);

  always_comb begin
    cand_o = cand_i;
    code_o = 4'd0;
    for (int k = 0; k < rrht_pkg::NumMethods; k++) begin
      if (len_i >= rrht_pkg::MethodLens[k] ||
          rrht_pkg::method_char(4'(k), len_i) != byte_i) begin
        cand_o[k] = 1'b0;
      end
      if (cand_i[k] && rrht_pkg::MethodLens[k] == len_i) begin
        code_o = 4'(k + 1);
      end
    end
  end

  assign len_o = (len_i < rrht_pkg::MethodLenMax) ? 4'(len_i + 4'd1) : len_i;

endmodule

@@ sv/rrht_parser.sv @@
// Per-byte parse state machine: holds the request phase, method candidates
// and field counter, and forms one result per step. Uses rrht_pkg and
// rrht_method_match.
module rrht_parser #(
  parameter int LENGTH_BITS = 13
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             step_i,
  input  logic                                             restart_i,
  input  logic [7:0]                                       byte_i,
  input  logic [rrht_pkg::NumLimits-1:0][LENGTH_BITS-1:0]  limit_i,
  output rrht_pkg::result_t                                result_o
);

  typedef enum logic [3:0] {
    PhStart       = 4'd0,
    PhMethod      = 4'd1,
    PhUrl         = 4'd2,
    PhVersion     = 4'd3,
    PhLineCr      = 4'd4,
    PhHdrStart    = 4'd5,
    PhHdrName     = 4'd6,
    PhHdrValue    = 4'd7,
    PhHdrCr       = 4'd8,
    PhEndCr       = 4'd9,
    PhInterleaved = 4'd10,
    PhError       = 4'd11
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [rrht_pkg::NumMethods-1:0] cand_q, cand_d;
  logic [3:0]                      mlen_q, mlen_d;
  logic [LENGTH_BITS-1:0]          flen_q, flen_d;
  logic [3:0]                      mm_q, mm_d;
  rrht_pkg::cause_e                cause_q, cause_d;

  logic [rrht_pkg::NumMethods-1:0] feed_cand, next_cand;
  logic [3:0]                      feed_len, next_len, match_code;

  // A new request starts matching from the full set
  assign feed_cand = (phase_q == PhStart) ? rrht_pkg::AllCandidates : cand_q;
  assign feed_len  = (phase_q == PhStart) ? 4'd0 : mlen_q;

  rrht_method_match u_match (
    .cand_i (feed_cand),
    .len_i  (feed_len),
    .byte_i (byte_i),
    .cand_o (next_cand),
    .len_o  (next_len),
    .code_o (match_code)
  );

  logic [LENGTH_BITS-1:0] flen_inc;
  assign flen_inc = LENGTH_BITS'(flen_q + 1'b1);

  always_comb begin
    rrht_pkg::role_e role;
    logic            fend, done;
    logic [7:0]      b;
    phase_d = phase_q;
    cand_d  = cand_q;
    mlen_d  = mlen_q;
    flen_d  = flen_q;
    mm_d    = mm_q;
    cause_d = cause_q;
    role    = rrht_pkg::RoleNone;
    fend    = 1'b0;
    done    = 1'b0;
    b       = byte_i;
    if (restart_i) begin
      phase_d = PhStart;
      cand_d  = rrht_pkg::AllCandidates;
      mlen_d  = 4'd0;
      flen_d  = '0;
      mm_d    = 4'd0;
      cause_d = rrht_pkg::CauseNone;
      b       = 8'd0;
    end else begin
      unique case (phase_q)
        PhStart: begin
          mm_d = 4'd0;
          if (b == rrht_pkg::ChDollar) begin
            phase_d = PhInterleaved;
            role    = rrht_pkg::RoleMark;
          end else if (rrht_pkg::is_upper(b)) begin
            cand_d  = next_cand;
            mlen_d  = next_len;
            phase_d = PhMethod;
            role    = rrht_pkg::RoleMethod;
          end else begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseChar;
          end
        end
        PhInterleaved: role = rrht_pkg::RoleMark;
        PhMethod: begin
          if (b == rrht_pkg::ChSpace) begin
            mm_d = match_code;
            if (match_code == 4'd0) begin
              phase_d = PhError;
              cause_d = rrht_pkg::CauseMethod;
            end else begin
              role    = rrht_pkg::RoleDelim;
              fend    = 1'b1;
              flen_d  = '0;
              phase_d = PhUrl;
            end
          end else if (rrht_pkg::is_upper(b) || b == rrht_pkg::ChUnder) begin
            cand_d = next_cand;
            mlen_d = next_len;
            role   = rrht_pkg::RoleMethod;
          end else begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseChar;
          end
        end
        PhUrl: begin
          if (b == rrht_pkg::ChSpace) begin
            role    = rrht_pkg::RoleDelim;
            fend    = 1'b1;
            flen_d  = '0;
            phase_d = PhVersion;
          end else if (!rrht_pkg::is_printable(b)) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseChar;
          end else if (flen_q >= limit_i[rrht_pkg::CfgMaxUrl]) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseLength;
          end else begin
            flen_d = flen_inc;
            role   = rrht_pkg::RoleUrl;
          end
        end
        PhVersion: begin
          if (b == rrht_pkg::ChCr || b == rrht_pkg::ChLf) begin
            role    = rrht_pkg::RoleDelim;
            fend    = 1'b1;
            phase_d = (b == rrht_pkg::ChCr) ? PhLineCr : PhHdrStart;
          end else if (!rrht_pkg::is_printable(b)) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseChar;
          end else if (flen_q >= limit_i[rrht_pkg::CfgMaxVersion]) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseLength;
          end else begin
            flen_d = flen_inc;
            role   = rrht_pkg::RoleVersion;
          end
        end
        PhLineCr, PhHdrCr: begin
          if (b == rrht_pkg::ChLf) begin
            role    = rrht_pkg::RoleDelim;
            phase_d = PhHdrStart;
          end else begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseEol;
          end
        end
        PhHdrStart: begin
          if (b == rrht_pkg::ChCr) begin
            role    = rrht_pkg::RoleDelim;
            phase_d = PhEndCr;
          end else if (b == rrht_pkg::ChLf) begin
            role    = rrht_pkg::RoleDelim;
            done    = 1'b1;
            phase_d = PhStart;
          end else if (!rrht_pkg::is_printable(b) || b == rrht_pkg::ChColon) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseChar;
          end else begin
            // name starts over at length zero; a zero limit refuses it
            flen_d = '0;
            if (limit_i[rrht_pkg::CfgMaxName] == '0) begin
              phase_d = PhError;
              cause_d = rrht_pkg::CauseLength;
            end else begin
              flen_d  = LENGTH_BITS'(1);
              role    = rrht_pkg::RoleName;
              phase_d = PhHdrName;
            end
          end
        end
        PhHdrName: begin
          if (b == rrht_pkg::ChColon) begin
            role    = rrht_pkg::RoleDelim;
            fend    = 1'b1;
            flen_d  = '0;
            phase_d = PhHdrValue;
          end else if (!rrht_pkg::is_printable(b)) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseChar;
          end else if (flen_q >= limit_i[rrht_pkg::CfgMaxName]) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseLength;
          end else begin
            flen_d = flen_inc;
            role   = rrht_pkg::RoleName;
          end
        end
        PhHdrValue: begin
          if (b == rrht_pkg::ChCr || b == rrht_pkg::ChLf) begin
            role    = rrht_pkg::RoleDelim;
            fend    = 1'b1;
            phase_d = (b == rrht_pkg::ChCr) ? PhHdrCr : PhHdrStart;
          end else if (flen_q >= limit_i[rrht_pkg::CfgMaxValue]) begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseLength;
          end else begin
            flen_d = flen_inc;
            role   = rrht_pkg::RoleValue;
          end
        end
        PhEndCr: begin
          if (b == rrht_pkg::ChLf) begin
            role    = rrht_pkg::RoleDelim;
            done    = 1'b1;
            phase_d = PhStart;
          end else begin
            phase_d = PhError;
            cause_d = rrht_pkg::CauseEol;
          end
        end
        default: phase_d = PhError;
      endcase
    end
    result_o.byte_out     = b;
    result_o.role         = role;
    result_o.field_end    = fend;
    result_o.method_code  = mm_d;
    result_o.request_done = done;
    result_o.error        = (phase_d == PhError);
    result_o.error_cause  = cause_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      cand_q  <= rrht_pkg::AllCandidates;
      mlen_q  <= 4'd0;
      flen_q  <= '0;
      mm_q    <= 4'd0;
      cause_q <= rrht_pkg::CauseNone;
    end else if (step_i) begin
      phase_q <= phase_d;
      cand_q  <= cand_d;
      mlen_q  <= mlen_d;
      flen_q  <= flen_d;
      mm_q    <= mm_d;
      cause_q <= cause_d;
    end
  end

endmodule

@@ sv/rtsp_request_header_tokenizer_top.sv @@
// Top level of the RTSP request header tokenizer: stream ports, limit
// registers, input and result registers. Uses rrht_pkg and rrht_parser.
//
// Path: an accepted item goes through the input register, then the result
// register, before it is shown on the master side.
// Throughput: one item per cycle unless stalled; the parse step for a byte
// is one pass through the phase machine and the eleven-way method compare.
// Reset (rst_ni low, asynchronous): parser to start of request, pipeline
// empty, limits to 2048/64/256/4096. Restart items clear the parser only.
module rtsp_request_header_tokenizer_top #(
  parameter int LENGTH_BITS = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] byte_in
  input  logic                              s_tuser,   // [0] opcode (1 = restart)
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] byte_out, [8] field_end, [12:9] method_code, [13] request_done,
  // [14] error, [17:15] error_cause, [23:18] zero
  output logic [23:0]                       m_tdata,
  output logic [2:0]                        m_tuser,   // [2:0] role
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [rrht_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [rrht_pkg::CfgDataBits-1:0]  cfg_data_i
);

  // Field length limits, indexed by the register codes of the package
  logic [rrht_pkg::NumLimits-1:0][LENGTH_BITS-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q[rrht_pkg::CfgMaxUrl]     <= LENGTH_BITS'(2048);
      limit_q[rrht_pkg::CfgMaxVersion] <= LENGTH_BITS'(64);
      limit_q[rrht_pkg::CfgMaxName]    <= LENGTH_BITS'(256);
      limit_q[rrht_pkg::CfgMaxValue]   <= LENGTH_BITS'(4096);
    end else if (cfg_we_i) begin
      limit_q[cfg_index_i] <= LENGTH_BITS'(cfg_data_i);
    end
  end

  // Input register feeds the parser; the result register holds its output.
  logic              in_valid_q;
  logic              in_op_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  rrht_pkg::result_t out_q;
  rrht_pkg::result_t step_res;

  logic out_free, step;
  assign out_free = !out_valid_q || m_tready;
  assign step     = in_valid_q && out_free;   // parser state advances here
  assign s_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid_q <= s_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_op_q   <= s_tuser;
      in_byte_q <= s_tdata;
    end
    if (step) begin
      out_q <= step_res;
    end
  end

  rrht_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .restart_i (in_op_q),
    .byte_i    (in_byte_q),
    .limit_i   (limit_q),
    .result_o  (step_res)
  );

  assign m_tvalid = out_valid_q;
  assign m_tuser  = out_q.role;
  assign m_tdata  = {6'd0, out_q.error_cause, out_q.error, out_q.request_done,
                     out_q.method_code, out_q.field_end, out_q.byte_out};

endmodule

@@ sv/rrht_checker.sv @@
// Port-level checks for the RTSP request header tokenizer, bound to the top
// level. Uses rrht_pkg for role and cause codes.
module rrht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // bytes in the error state carry no role
  a_err_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[14] |-> m_tuser == rrht_pkg::RoleNone)
    else $error("error item with a role");

  // a cause is reported exactly while in error
  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[14] == (m_tdata[17:15] != rrht_pkg::CauseNone))
    else $error("error flag and cause disagree");

  // field ends and request completion are only flagged on delimiters
  a_delim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tdata[8] || m_tdata[13]) |-> m_tuser == rrht_pkg::RoleDelim)
    else $error("field end or done on a non-delimiter");

endmodule

bind rtsp_request_header_tokenizer_top rrht_checker u_rrht_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ dv/rrht_parse_monitor.sv @@
// Stream monitor for the RTSP request header tokenizer: tracks limit writes,
// predicts one result per accepted item and compares each field.
// Depends on rrht_pkg for the port widths, result layout and code enums.
module rrht_parse_monitor #(
  parameter int LengthBits = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [7:0]                        s_tdata_i,   // [7:0] byte_in
  input  logic                              s_tuser_i,   // [0] opcode
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  // [7:0] byte_out, [8] field_end, [12:9] method_code, [13] request_done,
  // [14] error, [17:15] error_cause
  input  logic [23:0]                       m_tdata_i,
  input  logic [2:0]                        m_tuser_i,   // [2:0] role
  input  logic                              cfg_we_i,
  input  logic [rrht_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [rrht_pkg::CfgDataBits-1:0]  cfg_data_i,
  output int                                pending_o,
  output int                                mismatches_o,
  output int                                results_o,
  output int                                completed_o
);
  import rrht_pkg::*;

  typedef enum logic [3:0] {
    PhStart, PhMethod, PhUrl, PhVersion, PhLineCr, PhHdrStart, PhHdrName,
    PhHdrValue, PhHdrCr, PhEndCr, PhInterleaved, PhError
  } phase_e;

  string verb_text [NumMethods] = '{
    "DESCRIBE", "ANNOUNCE", "GET_PARAMETER", "OPTIONS", "PAUSE", "PLAY",
    "RECORD", "REDIRECT", "SETUP", "SET_PARAMETER", "TEARDOWN"
  };

  phase_e                phase;
  logic [NumMethods-1:0] cands;
  logic [3:0]            verb_len;
  logic [LengthBits-1:0] fld_len;
  logic [3:0]            verb_code;
  cause_e                reason;
  logic [LengthBits-1:0] lim_url, lim_ver, lim_name, lim_val;

  result_t tokens_due [$];
  int      n_bad = 0;
  int      n_results = 0;
  int      n_done = 0;

  assign mismatches_o = n_bad;
  assign results_o    = n_results;
  assign completed_o  = n_done;

  function automatic logic is_text(logic [7:0] b);
    return (b >= PrintLow) && (b <= PrintHigh);
  endfunction

  function automatic logic is_cap(logic [7:0] b);
    return (b >= ChUpperA) && (b <= ChUpperZ);
  endfunction

  function automatic void clear_parse();
    phase     = PhStart;
    cands     = AllCandidates;
    verb_len  = '0;
    fld_len   = '0;
    verb_code = '0;
    reason    = CauseNone;
  endfunction

  function automatic void go_error(cause_e c);
    phase  = PhError;
    reason = c;
  endfunction

  // Narrow the method candidates by one more character
  function automatic void feed_verb(logic [7:0] b);
    for (int k = 0; k < NumMethods; k++) begin
      if (cands[k] && (int'(verb_len) >= verb_text[k].len() ||
                       8'(verb_text[k][verb_len]) != b)) begin
        cands[k] = 1'b0;
      end
    end
    if (verb_len != MethodLenMax) verb_len = verb_len + 4'd1;
  endfunction

  // One more byte in a bounded field; flags a length error when full
  function automatic logic grow_field(logic [LengthBits-1:0] lim);
    if (fld_len >= lim) begin
      go_error(CauseLength);
      return 1'b0;
    end
    fld_len = fld_len + 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t next_token(logic op, logic [7:0] b);
    role_e      role;
    logic       fend;
    logic       done;
    logic [7:0] shown;
    result_t    r;
    role  = RoleNone;
    fend  = 1'b0;
    done  = 1'b0;
    shown = b;
    if (op) begin
      clear_parse();
      shown = '0;
    end else begin
      case (phase)
        PhStart: begin
          verb_code = '0;
          if (b == ChDollar) begin
            phase = PhInterleaved;
            role  = RoleMark;
          end else if (is_cap(b)) begin
            cands    = AllCandidates;
            verb_len = '0;
            feed_verb(b);
            phase = PhMethod;
            role  = RoleMethod;
          end else begin
            go_error(CauseChar);
          end
        end
        PhInterleaved: role = RoleMark;
        PhMethod: begin
          if (b == ChSpace) begin
            for (int k = 0; k < NumMethods; k++) begin
              if (cands[k] && verb_text[k].len() == int'(verb_len)) verb_code = 4'(k + 1);
            end
            if (verb_code == '0) begin
              go_error(CauseMethod);
            end else begin
              role    = RoleDelim;
              fend    = 1'b1;
              fld_len = '0;
              phase   = PhUrl;
            end
          end else if (is_cap(b) || b == ChUnder) begin
            feed_verb(b);
            role = RoleMethod;
          end else begin
            go_error(CauseChar);
          end
        end
        PhUrl: begin
          if (b == ChSpace) begin
            role    = RoleDelim;
            fend    = 1'b1;
            fld_len = '0;
            phase   = PhVersion;
          end else if (!is_text(b)) begin
            go_error(CauseChar);
          end else if (grow_field(lim_url)) begin
            role = RoleUrl;
          end
        end
        PhVersion: begin
          if (b == ChCr || b == ChLf) begin
            role  = RoleDelim;
            fend  = 1'b1;
            phase = (b == ChCr) ? PhLineCr : PhHdrStart;
          end else if (!is_text(b)) begin
            go_error(CauseChar);
          end else if (grow_field(lim_ver)) begin
            role = RoleVersion;
          end
        end
        PhLineCr, PhHdrCr: begin
          if (b == ChLf) begin
            role  = RoleDelim;
            phase = PhHdrStart;
          end else begin
            go_error(CauseEol);
          end
        end
        PhHdrStart: begin
          if (b == ChCr) begin
            role  = RoleDelim;
            phase = PhEndCr;
          end else if (b == ChLf) begin
            role  = RoleDelim;
            done  = 1'b1;
            phase = PhStart;
          end else if (!is_text(b) || b == ChColon) begin
            go_error(CauseChar);
          end else begin
            fld_len = '0;
            if (grow_field(lim_name)) begin
              role  = RoleName;
              phase = PhHdrName;
            end
          end
        end
        PhHdrName: begin
          if (b == ChColon) begin
            role    = RoleDelim;
            fend    = 1'b1;
            fld_len = '0;
            phase   = PhHdrValue;
          end else if (!is_text(b)) begin
            go_error(CauseChar);
          end else if (grow_field(lim_name)) begin
            role = RoleName;
          end
        end
        PhHdrValue: begin
          if (b == ChCr || b == ChLf) begin
            role  = RoleDelim;
            fend  = 1'b1;
            phase = (b == ChCr) ? PhHdrCr : PhHdrStart;
          end else if (grow_field(lim_val)) begin
            role = RoleValue;
          end
        end
        PhEndCr: begin
          if (b == ChLf) begin
            role  = RoleDelim;
            done  = 1'b1;
            phase = PhStart;
          end else begin
            go_error(CauseEol);
          end
        end
        default: phase = PhError;
      endcase
    end
    r.byte_out     = shown;
    r.role         = role;
    r.field_end    = fend;
    r.method_code  = verb_code;
    r.request_done = done;
    r.error        = (phase == PhError);
    r.error_cause  = reason;
    return r;
  endfunction

  function automatic void check_field(string tag, int unsigned want, int unsigned got);
    if (want != got) begin
      n_bad++;
      $display("%0t: %s expected %0d, got %0d", $time, tag, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      lim_url  = LengthBits'(2048);
      lim_ver  = LengthBits'(64);
      lim_name = LengthBits'(256);
      lim_val  = LengthBits'(4096);
      clear_parse();
      tokens_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CfgMaxUrl:     lim_url  = cfg_data_i[LengthBits-1:0];
          CfgMaxVersion: lim_ver  = cfg_data_i[LengthBits-1:0];
          CfgMaxName:    lim_name = cfg_data_i[LengthBits-1:0];
          CfgMaxValue:   lim_val  = cfg_data_i[LengthBits-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        n_results++;
        if (tokens_due.size() == 0) begin
          n_bad++;
          $display("%0t: result with nothing outstanding, expected none, got tdata %h tuser %h",
                   $time, m_tdata_i, m_tuser_i);
        end else begin
          due = tokens_due.pop_front();
          check_field("byte_out", due.byte_out, m_tdata_i[7:0]);
          check_field("role", due.role, m_tuser_i);
          check_field("field_end", due.field_end, m_tdata_i[8]);
          check_field("method_code", due.method_code, m_tdata_i[12:9]);
          check_field("request_done", due.request_done, m_tdata_i[13]);
          check_field("error", due.error, m_tdata_i[14]);
          check_field("error_cause", due.error_cause, m_tdata_i[17:15]);
          if (due.request_done) n_done++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        tokens_due.push_back(next_token(s_tuser_i, s_tdata_i));
      end
      pending_o <= tokens_due.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Top of the tokenizer regression: clock, reset, request generator, flow
// control and verdict. Depends on rrht_pkg, rrht_parse_monitor and the DUT.
module tb;
  import rrht_pkg::*;

  // Generous bound: ~1100 items plus one long hold-off
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 270;

  logic             clk = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [23:0]      m_tdata;
  logic [2:0]       m_tuser;
  logic             cfg_we = 1'b0;
  cfg_index_e       cfg_index = CfgMaxUrl;
  logic [CfgDataBits-1:0] cfg_data = '0;

  // Flow-control knobs, in percent: of items for sender gaps, of cycles for stalls
  int send_gap_pct = 0;
  int stall_pct    = 0;

  // Long receiver hold-off: requested by the stimulus, timed by the receiver
  bit hold_kick = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  int cycles = 0;
  int n_items = 0;
  int n_requests = 0;
  int pending, mismatches, results, completed;

  // Limits as last written, used to aim field lengths around them
  int unsigned limit_now [NumLimits] = '{2048, 64, 256, 4096};
  logic [7:0]  burst [$];

  string verbs [NumMethods] = '{
    "DESCRIBE", "ANNOUNCE", "GET_PARAMETER", "OPTIONS", "PAUSE", "PLAY",
    "RECORD", "REDIRECT", "SETUP", "SET_PARAMETER", "TEARDOWN"
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rtsp_request_header_tokenizer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rrht_parse_monitor u_mon (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .results_o    (results),
    .completed_o  (completed)
  );

  // Receiver: random stalls, plus one long hold-off so the block backs up
  // and has to drop s_tready while the sender keeps offering items.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_kick && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("rtsp_request_header_tokenizer_top regression: fail");
      $finish;
    end
  end

  // Offer one item and wait for the handshake. tvalid stays high on return so
  // back-to-back items see no bubble; the next call or drain decides.
  task automatic push_item(logic op, logic [7:0] b);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    n_items++;
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(1'b0, s[i]);
  endtask

  task automatic send_burst();
    foreach (burst[i]) push_item(1'b0, burst[i]);
    burst.delete();
  endtask

  // Restart item: byte content is don't-care, so randomize it
  task automatic restart_parser();
    push_item(1'b1, 8'($urandom_range(255)));
  endtask

  // Sender pauses until every predicted result has come out, plus latency
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four limits on consecutive cycles; block must be idle
  task automatic write_limits(int unsigned url, int unsigned ver, int unsigned name,
                              int unsigned val);
    int unsigned vals [NumLimits];
    cfg_index_e  idx;
    vals = '{url, ver, name, val};
    idx  = idx.first();
    cfg_we <= 1'b1;
    repeat (idx.num()) begin
      cfg_index <= idx;
      cfg_data  <= CfgDataBits'(vals[int'(idx)]);
      limit_now[int'(idx)] = vals[int'(idx)];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  // Field length aimed around a small limit, short otherwise
  function automatic int pick_len(int unsigned lim, int minl);
    int hi;
    hi = (lim < 20) ? int'(lim) + 1 : 12;
    if (hi < minl) hi = minl;
    return $urandom_range(hi, minl);
  endfunction

  function automatic logic [7:0] rand_text(bit no_colon);
    logic [7:0] b;
    do b = 8'($urandom_range(PrintHigh, PrintLow)); while (no_colon && b == ChColon);
    return b;
  endfunction

  function automatic void push_eol();
    if ($urandom_range(4) == 0) begin
      burst.push_back(ChLf);
    end else begin
      burst.push_back(ChCr);
      burst.push_back(ChLf);
    end
  endfunction

  // Builds one request into burst. Returns 1 when it may leave the parser in
  // error (unknown verb, a field over its limit), so a restart should follow.
  function automatic bit build_request();
    bit         risky;
    int         n;
    string      word;
    logic [7:0] b;
    risky = 1'b0;
    if ($urandom_range(9) == 0) begin
      // made-up verb, sometimes with a stray byte before the space
      n = $urandom_range(14, 1);
      for (int i = 0; i < n; i++) begin
        b = (i > 0 && $urandom_range(4) == 0) ? ChUnder : 8'($urandom_range(ChUpperZ, ChUpperA));
        burst.push_back(b);
      end
      if ($urandom_range(3) == 0) burst.push_back(8'($urandom_range(255)));
      risky = 1'b1;
    end else begin
      word = verbs[$urandom_range(NumMethods - 1)];
      for (int i = 0; i < word.len(); i++) burst.push_back(word[i]);
    end
    burst.push_back(ChSpace);
    n = pick_len(limit_now[CfgMaxUrl], 0);
    if (n > limit_now[CfgMaxUrl]) risky = 1'b1;
    repeat (n) burst.push_back(rand_text(1'b0));
    burst.push_back(ChSpace);
    if ($urandom_range(9) < 7) begin
      word = "RTSP/1.0";
      n = word.len();
      for (int i = 0; i < n; i++) burst.push_back(word[i]);
    end else begin
      n = pick_len(limit_now[CfgMaxVersion], 0);
      repeat (n) burst.push_back(rand_text(1'b0));
    end
    if (n > limit_now[CfgMaxVersion]) risky = 1'b1;
    push_eol();
    repeat ($urandom_range(4)) begin
      n = pick_len(limit_now[CfgMaxName], 1);
      if (n > limit_now[CfgMaxName]) risky = 1'b1;
      repeat (n) burst.push_back(rand_text(1'b1));
      burst.push_back(ChColon);
      // header values take any byte but the line terminators
      n = pick_len(limit_now[CfgMaxValue], 0);
      if (n > limit_now[CfgMaxValue]) risky = 1'b1;
      repeat (n) begin
        do b = 8'($urandom_range(255)); while (b == ChCr || b == ChLf);
        burst.push_back(b);
      end
      push_eol();
    end
    push_eol();
    return risky;
  endfunction

  // Damage a built request: overwrite a byte, cut it short, or slip in a CR
  function automatic void corrupt_burst();
    int p;
    p = $urandom_range(burst.size() - 1);
    case ($urandom_range(2))
      0: burst[p] = 8'($urandom_range(255));
      1: while (burst.size() > p + 1) void'(burst.pop_back());
      default: burst.insert(p, ChCr);
    endcase
  endfunction

  // Mostly well-formed requests with random content; the rest is damaged
  // requests, interleaved-data markers and raw noise, each closed by a restart.
  task automatic run_traffic(int quota, bit with_hold);
    int  start;
    int  pick;
    bit  risky;
    start = n_items;
    while (n_items - start < quota) begin
      if (with_hold && n_items - start > quota / 3) hold_kick <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 68) begin
        risky = build_request();
        n_requests++;
        send_burst();
        if (risky || $urandom_range(4) == 0) restart_parser();
      end else if (pick < 82) begin
        void'(build_request());
        n_requests++;
        corrupt_burst();
        send_burst();
        restart_parser();
      end else if (pick < 88) begin
        burst.push_back(ChDollar);
        repeat ($urandom_range(5)) burst.push_back(8'($urandom_range(255)));
        send_burst();
        restart_parser();
      end else begin
        repeat ($urandom_range(6, 1)) begin
          push_item($urandom_range(3) == 0, 8'($urandom_range(255)));
        end
        restart_parser();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: restart with all-ones byte; a request line whose first header
    // starts with ':' (empty name refused), then a byte in the error state;
    // interleaved marker with a zero byte; a verb that is only a prefix of a
    // real method; a lowercase first byte.
    push_item(1'b1, 8'hFF);
    feed_text("PLAY / R\n:");
    push_item(1'b0, 8'hFF);
    push_item(1'b1, 8'h00);
    feed_text("$");
    push_item(1'b0, 8'h00);
    push_item(1'b1, 8'hA5);
    feed_text("GET ");
    push_item(1'b1, 8'h5A);
    feed_text("a");
    push_item(1'b1, 8'h00);

    // Phase 1: no idling, reset limits, long receiver hold-off mid-phase
    run_traffic(PhaseItems, 1'b1);
    drain();

    // Phase 2: largest limits, sender idles
    write_limits(8191, 8191, 8191, 8191);
    send_gap_pct = 46;
    run_traffic(PhaseItems, 1'b0);
    drain();

    // Phase 3: limits of one, receiver stalls
    write_limits(1, 1, 1, 1);
    send_gap_pct = 0;
    stall_pct    = 46;
    run_traffic(PhaseItems, 1'b0);
    drain();

    // Phase 4: small random limits, both sides idle
    write_limits($urandom_range(24, 2), $urandom_range(24, 2), $urandom_range(24, 2),
                 $urandom_range(24, 2));
    send_gap_pct = 33;
    stall_pct    = 33;
    run_traffic(PhaseItems, 1'b0);
    drain();

    $display("Covered %0d items: %0d generated requests plus directed cases, noise and restarts,",
             n_items, n_requests);
    $display("across four flow-control mixes and four limit sets; %0d results checked, %0d completed.",
             results, completed);
    if (mismatches == 0) begin
      $display("rtsp_request_header_tokenizer_top regression: pass");
    end else begin
      $display("rtsp_request_header_tokenizer_top regression: fail");
    end
    $finish;
  end

endmodule
